// ----- rtl/core/ndt_pkg.sv -----
// Shared constants, codes and control structures for the nearest point delay table.
package ndt_pkg;

	localparam int ROWS_PER_TABLE = 16;
	localparam int ARC_SLOTS = 8;
	localparam int KINDS = 8;

	localparam int KIND_W = 3;
	localparam int VAL_W = 16;
	localparam int DELAY_W = 17;
	localparam int DIST_W = 2 * VAL_W + 1;
	localparam int ROW_W = 3 * VAL_W;

	localparam int CNT_W = $clog2(ROWS_PER_TABLE + 1);
	localparam int RIDX_W = (ROWS_PER_TABLE > 1) ? $clog2(ROWS_PER_TABLE) : 1;
	localparam int ROW_DEPTH = KINDS * ROWS_PER_TABLE;
	localparam int ROW_AW = $clog2(ROW_DEPTH);
	localparam int ACNT_W = $clog2(ARC_SLOTS + 1);
	localparam int AIDX_W = (ARC_SLOTS > 1) ? $clog2(ARC_SLOTS) : 1;

	typedef enum logic [1:0] {
		OP_ADD_ROW = 2'd0,
		OP_ADD_ARC = 2'd1,
		OP_QUERY   = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SRC_NONE  = 2'd0,
		SRC_TABLE = 2'd1,
		SRC_ARC   = 2'd2
	} src_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_TBL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              capture;
		logic              exec;
		logic              rd_en;
		logic [RIDX_W-1:0] rd_idx;
		logic              rd_first;
		logic              res_tbl;
		logic              out_ld;
	} ndt_cmd_t;

	typedef struct packed {
		logic             scan_needed;
		logic [CNT_W-1:0] kind_fill;
	} ndt_sts_t;

endpackage

// ----- rtl/core/nearest_point_delay_table.sv -----
// Top level of the nearest point delay table: controller, datapath and checks.
// An add, an unused code or a query of an empty table goes from execute to finish.
// A query over n stored rows reads one row a cycle from the row memory, then passes
// through the distance and compare pipeline, then loads the result.
// The result word waits in an output register; the next result stalls until it is taken.
// Reset clears the row counts, arc count and handshake state; stored data is unknown.
module nearest_point_delay_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  operation,
	input  logic [ndt_pkg::KIND_W-1:0]  arc_kind,
	input  logic [ndt_pkg::VAL_W-1:0]   slew,
	input  logic [ndt_pkg::VAL_W-1:0]   load,
	input  logic [ndt_pkg::VAL_W-1:0]   delay_or_rise,
	input  logic [ndt_pkg::VAL_W-1:0]   fall,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ndt_pkg::DELAY_W-1:0] delay_out,
	output logic [1:0]                  source,
	output logic                        dropped
);

	ndt_pkg::ndt_cmd_t cmd;
	ndt_pkg::ndt_sts_t sts;

	ndt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ndt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.arc_kind      (arc_kind),
		.slew          (slew),
		.load          (load),
		.delay_or_rise (delay_or_rise),
		.fall          (fall),
		.delay_out     (delay_out),
		.source        (source),
		.dropped       (dropped)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Block accepted a word and stayed ready.");

	a_drop_has_no_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> source == ndt_pkg::SRC_NONE && delay_out == '0)
		else $error("Dropped add reported a delay or source.");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && source == ndt_pkg::SRC_NONE |-> delay_out == '0)
		else $error("Result without a source carries a nonzero delay.");

	a_table_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && source == ndt_pkg::SRC_TABLE |-> !delay_out[0])
		else $error("Table delay is not a doubled row value.");

endmodule

// ----- rtl/core/ndt_ctrl.sv -----
// Controller state machine that sequences add, scan and result delivery.
module ndt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ndt_pkg::ndt_sts_t sts,
	output ndt_pkg::ndt_cmd_t cmd
);

	ndt_pkg::state_t state_q, state_d;
	logic [ndt_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ndt_pkg::ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.rd_idx = cnt_q[ndt_pkg::RIDX_W-1:0];
		cmd.rd_first = (cnt_q == '0);
		in_ready = 1'b0;
		case (state_q)
			ndt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = ndt_pkg::ST_EXEC;
				end
			end
			ndt_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				cnt_d = '0;
				state_d = sts.scan_needed ? ndt_pkg::ST_SCAN : ndt_pkg::ST_FINISH;
			end
			ndt_pkg::ST_SCAN: begin
				cmd.rd_en = 1'b1;
				cnt_d = ndt_pkg::CNT_W'(cnt_q + ndt_pkg::CNT_W'(1));
				if (cnt_d == sts.kind_fill) begin
					state_d = ndt_pkg::ST_DRAIN1;
				end
			end
			ndt_pkg::ST_DRAIN1: begin
				state_d = ndt_pkg::ST_DRAIN2;
			end
			ndt_pkg::ST_DRAIN2: begin
				state_d = ndt_pkg::ST_TBL;
			end
			ndt_pkg::ST_TBL: begin
				cmd.res_tbl = 1'b1;
				state_d = ndt_pkg::ST_FINISH;
			end
			ndt_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_ld = 1'b1;
					state_d = ndt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ndt_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/ndt_dp.sv -----
// Datapath with the row memory, arc list, distance pipeline and result registers.
module ndt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ndt_pkg::ndt_cmd_t             cmd,
	output ndt_pkg::ndt_sts_t             sts,
	input  logic [1:0]                    operation,
	input  logic [ndt_pkg::KIND_W-1:0]    arc_kind,
	input  logic [ndt_pkg::VAL_W-1:0]     slew,
	input  logic [ndt_pkg::VAL_W-1:0]     load,
	input  logic [ndt_pkg::VAL_W-1:0]     delay_or_rise,
	input  logic [ndt_pkg::VAL_W-1:0]     fall,
	output logic [ndt_pkg::DELAY_W-1:0]   delay_out,
	output logic [1:0]                    source,
	output logic                          dropped
);

	ndt_pkg::op_t op_q;
	logic [ndt_pkg::KIND_W-1:0] kind_q;
	logic [ndt_pkg::VAL_W-1:0] slew_q, load_q, dr_q, fall_q;

	logic [ndt_pkg::CNT_W-1:0] row_counts_q [ndt_pkg::KINDS];
	logic [ndt_pkg::ACNT_W-1:0] arc_count_q;
	logic [ndt_pkg::KIND_W-1:0] arc_kind_q [ndt_pkg::ARC_SLOTS];
	logic [ndt_pkg::VAL_W-1:0] arc_rise_q [ndt_pkg::ARC_SLOTS];
	logic [ndt_pkg::VAL_W-1:0] arc_fall_q [ndt_pkg::ARC_SLOTS];

	logic [ndt_pkg::ROW_W-1:0] row_mem [ndt_pkg::ROW_DEPTH];

	logic [ndt_pkg::CNT_W-1:0] cnt_k;
	logic row_full, arc_full;
	logic [ndt_pkg::ROW_AW-1:0] wr_addr, rd_addr;

	logic [ndt_pkg::ROW_W-1:0] rd_data_s1;
	logic v_s1, first_s1;
	logic [2*ndt_pkg::VAL_W-1:0] sq_s_s2, sq_l_s2;
	logic [ndt_pkg::VAL_W-1:0] delay_s2;
	logic v_s2, first_s2;
	logic [ndt_pkg::VAL_W-1:0] rs, rl, ds, dl;
	logic [ndt_pkg::DIST_W-1:0] row_dist;
	logic [ndt_pkg::DIST_W-1:0] best_q;
	logic [ndt_pkg::VAL_W-1:0] best_delay_q;

	logic arc_hit;
	logic [ndt_pkg::DELAY_W-1:0] arc_sum;
	logic [ndt_pkg::DELAY_W-1:0] ex_delay;
	ndt_pkg::src_t ex_src;
	logic ex_drop;

	logic [ndt_pkg::DELAY_W-1:0] res_delay_q;
	ndt_pkg::src_t res_src_q;
	logic res_drop_q;
	logic [ndt_pkg::DELAY_W-1:0] out_delay_q;
	ndt_pkg::src_t out_src_q;
	logic out_drop_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= ndt_pkg::op_t'(operation);
			kind_q <= arc_kind;
			slew_q <= slew;
			load_q <= load;
			dr_q <= delay_or_rise;
			fall_q <= fall;
		end
	end

	assign cnt_k = row_counts_q[kind_q];
	assign row_full = (cnt_k >= ndt_pkg::CNT_W'(ndt_pkg::ROWS_PER_TABLE));
	assign arc_full = (arc_count_q >= ndt_pkg::ACNT_W'(ndt_pkg::ARC_SLOTS));
	assign wr_addr = ndt_pkg::ROW_AW'(ndt_pkg::ROW_AW'(kind_q)
		* ndt_pkg::ROW_AW'(ndt_pkg::ROWS_PER_TABLE)
		+ ndt_pkg::ROW_AW'(cnt_k[ndt_pkg::RIDX_W-1:0]));
	assign rd_addr = ndt_pkg::ROW_AW'(ndt_pkg::ROW_AW'(kind_q)
		* ndt_pkg::ROW_AW'(ndt_pkg::ROWS_PER_TABLE)
		+ ndt_pkg::ROW_AW'(cmd.rd_idx));

	always_comb begin
		sts.scan_needed = (op_q == ndt_pkg::OP_QUERY) && (cnt_k != '0);
		sts.kind_fill = cnt_k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ndt_pkg::KINDS; k++) begin
				row_counts_q[k] <= '0;
			end
			arc_count_q <= '0;
		end else if (cmd.exec) begin
			if (op_q == ndt_pkg::OP_ADD_ROW && !row_full) begin
				row_counts_q[kind_q] <= ndt_pkg::CNT_W'(cnt_k + ndt_pkg::CNT_W'(1));
			end
			if (op_q == ndt_pkg::OP_ADD_ARC && !arc_full) begin
				arc_count_q <= ndt_pkg::ACNT_W'(arc_count_q + ndt_pkg::ACNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == ndt_pkg::OP_ADD_ARC && !arc_full) begin
			arc_kind_q[arc_count_q[ndt_pkg::AIDX_W-1:0]] <= kind_q;
			arc_rise_q[arc_count_q[ndt_pkg::AIDX_W-1:0]] <= dr_q;
			arc_fall_q[arc_count_q[ndt_pkg::AIDX_W-1:0]] <= fall_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == ndt_pkg::OP_ADD_ROW && !row_full) begin
			row_mem[wr_addr] <= {slew_q, load_q, dr_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_s1 <= row_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	assign rs = rd_data_s1[3*ndt_pkg::VAL_W-1:2*ndt_pkg::VAL_W];
	assign rl = rd_data_s1[2*ndt_pkg::VAL_W-1:ndt_pkg::VAL_W];
	assign ds = (slew_q >= rs) ? ndt_pkg::VAL_W'(slew_q - rs) : ndt_pkg::VAL_W'(rs - slew_q);
	assign dl = (load_q >= rl) ? ndt_pkg::VAL_W'(load_q - rl) : ndt_pkg::VAL_W'(rl - load_q);

	always_ff @(posedge clk) begin
		first_s1 <= cmd.rd_first;
		first_s2 <= first_s1;
		sq_s_s2 <= ds * ds;
		sq_l_s2 <= dl * dl;
		delay_s2 <= rd_data_s1[ndt_pkg::VAL_W-1:0];
	end

	assign row_dist = ndt_pkg::DIST_W'(sq_s_s2) + ndt_pkg::DIST_W'(sq_l_s2);

	always_ff @(posedge clk) begin
		if (v_s2 && (first_s2 || row_dist < best_q)) begin
			best_q <= row_dist;
			best_delay_q <= delay_s2;
		end
	end

	always_comb begin
		arc_hit = 1'b0;
		arc_sum = '0;
		for (int i = 0; i < ndt_pkg::ARC_SLOTS; i++) begin
			if (!arc_hit && ndt_pkg::ACNT_W'(i) < arc_count_q && arc_kind_q[i] == kind_q) begin
				arc_hit = 1'b1;
				arc_sum = ndt_pkg::DELAY_W'(arc_rise_q[i]) + ndt_pkg::DELAY_W'(arc_fall_q[i]);
			end
		end
	end

	always_comb begin
		ex_delay = '0;
		ex_src = ndt_pkg::SRC_NONE;
		ex_drop = 1'b0;
		case (op_q)
			ndt_pkg::OP_ADD_ROW: begin
				ex_drop = row_full;
			end
			ndt_pkg::OP_ADD_ARC: begin
				ex_drop = arc_full;
			end
			ndt_pkg::OP_QUERY: begin
				if (arc_hit) begin
					ex_delay = arc_sum;
					ex_src = ndt_pkg::SRC_ARC;
				end
			end
			default: begin
				ex_drop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_delay_q <= ex_delay;
			res_src_q <= ex_src;
			res_drop_q <= ex_drop;
		end else if (cmd.res_tbl) begin
			res_delay_q <= {best_delay_q, 1'b0};
			res_src_q <= ndt_pkg::SRC_TABLE;
			res_drop_q <= 1'b0;
		end
		if (cmd.out_ld) begin
			out_delay_q <= res_delay_q;
			out_src_q <= res_src_q;
			out_drop_q <= res_drop_q;
		end
	end

	assign delay_out = out_delay_q;
	assign source = out_src_q;
	assign dropped = out_drop_q;

endmodule
